// ===== hdl/tct_pkg.sv =====
// tct_pkg: shared types and constants of the touch coordinate transform
// register codes, rotation codes and the mode bundle; no dependencies
`default_nettype none

package tct_pkg;

	// apb port geometry
	localparam int unsigned APB_DATA_BITS = 32;
	localparam int unsigned APB_ADDR_BITS = 5;

	// register index, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_NATIVE_WIDTH,
		REG_NATIVE_HEIGHT,
		REG_LOGICAL_WIDTH,
		REG_LOGICAL_HEIGHT,
		REG_MIRROR_H,
		REG_MIRROR_V,
		REG_SWAP_AXES,
		REG_ROTATION
	} tct_reg_t;

	// quadrant rotation codes
	typedef enum logic [1:0] {
		ROT_0,
		ROT_90,
		ROT_180,
		ROT_270
	} tct_rot_t;

	// orientation controls from the register file
	typedef struct packed {
		logic     mirror_h;
		logic     mirror_v;
		logic     swap;
		tct_rot_t rot;
	} tct_mode_t;

endpackage

`default_nettype wire

// ===== hdl/tct_in_if.sv =====
// tct_in_if: valid/ready channel carrying one raw touch point
// no dependencies
`default_nettype none

interface tct_in_if #(
	parameter int unsigned W = 16
);
	logic         valid;
	logic         ready;
	logic [W-1:0] raw_x;
	logic [W-1:0] raw_y;

	modport source (output valid, output raw_x, output raw_y, input ready);
	modport sink (input valid, input raw_x, input raw_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/tct_out_if.sv =====
// tct_out_if: valid/ready channel carrying one logical screen point
// no dependencies
`default_nettype none

interface tct_out_if #(
	parameter int unsigned W = 16
);
	logic         valid;
	logic         ready;
	logic [W-1:0] screen_x;
	logic [W-1:0] screen_y;

	modport source (output valid, output screen_x, output screen_y, input ready);
	modport sink (input valid, input screen_x, input screen_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/tct_regs.sv =====
// tct_regs: apb register file holding extents and orientation controls
// depends on tct_pkg
`default_nettype none

module tct_regs #(
	parameter int unsigned W = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tct_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [tct_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [tct_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                    pready,
	output logic      [W-1:0]                       native_w,
	output logic      [W-1:0]                       native_h,
	output logic      [W-1:0]                       logical_w,
	output logic      [W-1:0]                       logical_h,
	output tct_pkg::tct_mode_t                      mode
);
	import tct_pkg::*;

	logic [W-1:0] native_w_q;
	logic [W-1:0] native_h_q;
	logic [W-1:0] logical_w_q;
	logic [W-1:0] logical_h_q;
	tct_mode_t    mode_q;
	tct_reg_t     index;
	logic         wr;

	// decode, low address bits ignored
	assign index  = tct_reg_t'(paddr[APB_ADDR_BITS-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			native_w_q  <= '0;
			native_h_q  <= '0;
			logical_w_q <= W'(1);
			logical_h_q <= W'(1);
			mode_q      <= '0;
		end else if (wr) begin
			unique case (index)
				REG_NATIVE_WIDTH:   native_w_q      <= pwdata[W-1:0];
				REG_NATIVE_HEIGHT:  native_h_q      <= pwdata[W-1:0];
				REG_LOGICAL_WIDTH:  logical_w_q     <= pwdata[W-1:0];
				REG_LOGICAL_HEIGHT: logical_h_q     <= pwdata[W-1:0];
				REG_MIRROR_H:       mode_q.mirror_h <= pwdata[0];
				REG_MIRROR_V:       mode_q.mirror_v <= pwdata[0];
				REG_SWAP_AXES:      mode_q.swap     <= pwdata[0];
				REG_ROTATION:       mode_q.rot      <= tct_rot_t'(pwdata[1:0]);
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (index)
			REG_NATIVE_WIDTH:   prdata = APB_DATA_BITS'(native_w_q);
			REG_NATIVE_HEIGHT:  prdata = APB_DATA_BITS'(native_h_q);
			REG_LOGICAL_WIDTH:  prdata = APB_DATA_BITS'(logical_w_q);
			REG_LOGICAL_HEIGHT: prdata = APB_DATA_BITS'(logical_h_q);
			REG_MIRROR_H:       prdata = APB_DATA_BITS'(mode_q.mirror_h);
			REG_MIRROR_V:       prdata = APB_DATA_BITS'(mode_q.mirror_v);
			REG_SWAP_AXES:      prdata = APB_DATA_BITS'(mode_q.swap);
			REG_ROTATION:       prdata = APB_DATA_BITS'(mode_q.rot);
		endcase
	end

	assign native_w  = native_w_q;
	assign native_h  = native_h_q;
	assign logical_w = logical_w_q;
	assign logical_h = logical_h_q;
	assign mode      = mode_q;

endmodule

`default_nettype wire

// ===== hdl/tct_prep.sv =====
// tct_prep: first stage, mirror and swap, classify each axis against its divisor
// depends on tct_pkg
`default_nettype none

module tct_prep #(
	parameter int unsigned W = 16
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [W-1:0]  raw_x,
	input  wire logic [W-1:0]  raw_y,
	input  wire logic [W-1:0]  native_w,
	input  wire logic [W-1:0]  native_h,
	input  wire logic [W-1:0]  div_x,
	input  wire logic [W-1:0]  div_y,
	input  tct_pkg::tct_mode_t mode,
	output logic      [W-1:0]  pos_x_s1,
	output logic      [W-1:0]  pos_y_s1,
	output logic               zero_x_s1,
	output logic               zero_y_s1,
	output logic               over_x_s1,
	output logic               over_y_s1
);
	import tct_pkg::*;

	logic [W:0] mx;
	logic [W:0] my;
	logic [W:0] px;
	logic [W:0] py;
	logic       zero_x;
	logic       zero_y;
	logic       over_x;
	logic       over_y;

	// mirror in two's complement, one sign bit over the coordinate width
	always_comb begin
		mx = mode.mirror_h ? ({1'b0, native_w} - {1'b0, raw_x} - (W+1)'(1)) : {1'b0, raw_x};
		my = mode.mirror_v ? ({1'b0, native_h} - {1'b0, raw_y} - (W+1)'(1)) : {1'b0, raw_y};
		px = mode.swap ? my : mx;
		py = mode.swap ? mx : my;
	end

	// non-positive scales to zero, at or past the extent clamps to the top
	always_comb begin
		zero_x = px[W] || (px == '0);
		zero_y = py[W] || (py == '0);
		over_x = !px[W] && (px >= {1'b0, div_x});
		over_y = !py[W] && (py >= {1'b0, div_y});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_x_s1  <= px[W-1:0];
			pos_y_s1  <= py[W-1:0];
			zero_x_s1 <= zero_x;
			zero_y_s1 <= zero_y;
			over_x_s1 <= over_x;
			over_y_s1 <= over_y;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/tct_axis.sv =====
// tct_axis: one axis, multiply by logical size then pipelined restoring divide
// one quotient bit per stage; depends on nothing outside this file
`default_nettype none

module tct_axis #(
	parameter int unsigned W = 16
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] pos_s1,
	input  wire logic         zero_s1,
	input  wire logic         over_s1,
	input  wire logic [W-1:0] lsize,
	input  wire logic [W-1:0] div,
	output logic      [W-1:0] quo,
	output logic              zero,
	output logic              over
);
	logic [2*W-1:0] prod;
	logic [W-1:0]   rem_s  [W+1];
	logic [W-1:0]   low_s  [W+1];
	logic [W-1:0]   quo_s  [W+1];
	logic           zero_s [W+1];
	logic           over_s [W+1];

	// product stage; high half is below the divisor whenever the result is used
	assign prod = {{W{1'b0}}, pos_s1} * {{W{1'b0}}, lsize};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= prod[2*W-1:W];
			low_s[0]  <= prod[W-1:0];
			quo_s[0]  <= '0;
			zero_s[0] <= zero_s1;
			over_s[0] <= over_s1;
		end
	end

	// divider stages, one compare and subtract each
	for (genvar k = 1; k <= W; k++) begin : g_stage
		logic [W:0] trial;
		logic       ge;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][W-1]};
			ge    = trial >= {1'b0, div};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? W'(trial - {1'b0, div}) : trial[W-1:0];
				low_s[k]  <= {low_s[k-1][W-2:0], 1'b0};
				quo_s[k]  <= {quo_s[k-1][W-2:0], ge};
				zero_s[k] <= zero_s[k-1];
				over_s[k] <= over_s[k-1];
			end
		end
	end

	assign quo  = quo_s[W];
	assign zero = zero_s[W];
	assign over = over_s[W];

endmodule

`default_nettype wire

// ===== hdl/tct_post.sv =====
// tct_post: clamp both axes and rotate by quadrant into the output register
// depends on tct_pkg
`default_nettype none

module tct_post #(
	parameter int unsigned W = 16
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] quo_x,
	input  wire logic         zero_x,
	input  wire logic         over_x,
	input  wire logic [W-1:0] quo_y,
	input  wire logic         zero_y,
	input  wire logic         over_y,
	input  wire logic [W-1:0] lw,
	input  wire logic [W-1:0] lh,
	input  tct_pkg::tct_rot_t rot,
	output logic      [W-1:0] screen_x,
	output logic      [W-1:0] screen_y
);
	import tct_pkg::*;

	logic [W-1:0] lw_m1;
	logic [W-1:0] lh_m1;
	logic [W-1:0] lx;
	logic [W-1:0] ly;
	logic [W-1:0] rx;
	logic [W-1:0] ry;
	logic [W-1:0] x_s_out;
	logic [W-1:0] y_s_out;

	// clamp to the logical range
	always_comb begin
		lw_m1 = lw - W'(1);
		lh_m1 = lh - W'(1);
		lx    = zero_x ? '0 : (over_x ? lw_m1 : quo_x);
		ly    = zero_y ? '0 : (over_y ? lh_m1 : quo_y);
	end

	// quadrant rotation
	always_comb begin
		unique case (rot)
			ROT_0: begin
				rx = lx;
				ry = ly;
			end
			ROT_90: begin
				rx = ly;
				ry = lw_m1 - lx;
			end
			ROT_180: begin
				rx = lw_m1 - lx;
				ry = lh_m1 - ly;
			end
			ROT_270: begin
				rx = lh_m1 - ly;
				ry = lx;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s_out <= rx;
			y_s_out <= ry;
		end
	end

	assign screen_x = x_s_out;
	assign screen_y = y_s_out;

endmodule

`default_nettype wire

// ===== hdl/touch_coordinate_transform.sv =====
// touch_coordinate_transform: raw touch point to logical screen point
// depends on tct_pkg, tct_in_if, tct_out_if, tct_regs, tct_prep, tct_axis, tct_post
//
//   channel   direction   transfer contents
//   touch     in          raw_x, raw_y (native counts)
//   screen    out         screen_x, screen_y (logical pixels)
//   apb       in/out      register writes and reads, a setup then an access phase, pready held high
//
// one point per cycle while the output is taken; the divider resolves one quotient bit
// per stage, after the prep and multiply stages and ahead of the output stage.
// reset clears the valid chain and resets the register file, logical sizes to one; no clearing pass.
// a stall at the output freezes the whole pipeline; nothing is dropped or repeated.
`default_nettype none

module touch_coordinate_transform #(
	parameter int unsigned COORD_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [tct_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  wire logic [tct_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic      [tct_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                    pready,
	tct_in_if.sink                                  touch,
	tct_out_if.source                               screen
);
	import tct_pkg::*;

	localparam int unsigned W     = COORD_BITS;
	localparam int unsigned DEPTH = W + 3;

	logic [W-1:0] native_w;
	logic [W-1:0] native_h;
	logic [W-1:0] logical_w;
	logic [W-1:0] logical_h;
	tct_mode_t    mode;
	logic [W-1:0] nat_x;
	logic [W-1:0] nat_y;
	logic [W-1:0] div_x;
	logic [W-1:0] div_y;
	logic [W-1:0] lw;
	logic [W-1:0] lh;
	logic         en;
	logic [DEPTH-1:0] valid_s;

	logic [W-1:0] pos_x_s1;
	logic [W-1:0] pos_y_s1;
	logic         zero_x_s1;
	logic         zero_y_s1;
	logic         over_x_s1;
	logic         over_y_s1;
	logic [W-1:0] quo_x;
	logic [W-1:0] quo_y;
	logic         zero_x;
	logic         zero_y;
	logic         over_x;
	logic         over_y;

	tct_regs #(.W(W)) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.native_w  (native_w),
		.native_h  (native_h),
		.logical_w (logical_w),
		.logical_h (logical_h),
		.mode      (mode)
	);

	// divisors after the swap, zero extent taken as one; same for logical sizes
	always_comb begin
		nat_x = mode.swap ? native_h : native_w;
		nat_y = mode.swap ? native_w : native_h;
		div_x = (nat_x == '0) ? W'(1) : nat_x;
		div_y = (nat_y == '0) ? W'(1) : nat_y;
		lw    = (logical_w == '0) ? W'(1) : logical_w;
		lh    = (logical_h == '0) ? W'(1) : logical_h;
	end

	// whole pipeline advances unless a finished point waits at the output
	assign en          = !valid_s[DEPTH-1] || screen.ready;
	assign touch.ready = en;
	assign screen.valid = valid_s[DEPTH-1];

	// valid chain, one bit per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[DEPTH-2:0], touch.valid};
		end
	end

	tct_prep #(.W(W)) u_prep (
		.clk       (clk),
		.en        (en),
		.raw_x     (touch.raw_x),
		.raw_y     (touch.raw_y),
		.native_w  (native_w),
		.native_h  (native_h),
		.div_x     (div_x),
		.div_y     (div_y),
		.mode      (mode),
		.pos_x_s1  (pos_x_s1),
		.pos_y_s1  (pos_y_s1),
		.zero_x_s1 (zero_x_s1),
		.zero_y_s1 (zero_y_s1),
		.over_x_s1 (over_x_s1),
		.over_y_s1 (over_y_s1)
	);

	// x scales by logical width, y by logical height
	tct_axis #(.W(W)) u_axis_x (
		.clk     (clk),
		.en      (en),
		.pos_s1  (pos_x_s1),
		.zero_s1 (zero_x_s1),
		.over_s1 (over_x_s1),
		.lsize   (lw),
		.div     (div_x),
		.quo     (quo_x),
		.zero    (zero_x),
		.over    (over_x)
	);

	tct_axis #(.W(W)) u_axis_y (
		.clk     (clk),
		.en      (en),
		.pos_s1  (pos_y_s1),
		.zero_s1 (zero_y_s1),
		.over_s1 (over_y_s1),
		.lsize   (lh),
		.div     (div_y),
		.quo     (quo_y),
		.zero    (zero_y),
		.over    (over_y)
	);

	tct_post #(.W(W)) u_post (
		.clk      (clk),
		.en       (en),
		.quo_x    (quo_x),
		.zero_x   (zero_x),
		.over_x   (over_x),
		.quo_y    (quo_y),
		.zero_y   (zero_y),
		.over_y   (over_y),
		.lw       (lw),
		.lh       (lh),
		.rot      (mode.rot),
		.screen_x (screen.screen_x),
		.screen_y (screen.screen_y)
	);

endmodule

`default_nettype wire

// ===== hdl/tct_chk.sv =====
// tct_chk: port-level checks on the touch coordinate transform, bound to the top
// depends on touch_coordinate_transform
`default_nettype none

module tct_chk #(
	parameter int unsigned W = 16
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         in_valid,
	input wire logic         in_ready,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [W-1:0] out_x,
	input wire logic [W-1:0] out_y
);

	// input side opens exactly when the output slot is free or drains
	a_ready_follows_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x) && $stable(out_y)))
		else $error("stalled result changed or vanished");

	// nothing leaves in the first cycle after reset
	a_no_result_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result shown right after reset");

	// a full output slot with no taker blocks new input
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && in_valid) |=> $stable(out_x))
		else $error("input taken over a stalled result");

endmodule

bind touch_coordinate_transform tct_chk #(.W(COORD_BITS)) u_tct_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (touch.valid),
	.in_ready  (touch.ready),
	.out_valid (screen.valid),
	.out_ready (screen.ready),
	.out_x     (screen.screen_x),
	.out_y     (screen.screen_y)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for touch_coordinate_transform, driving touch points and
// register writes and comparing every screen point with a local transform predictor
// depends on tct_pkg, tct_in_if, tct_out_if and the touch_coordinate_transform rtl
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tct_pkg::*;

	localparam int unsigned COORD_BITS   = 16;
	localparam int          PIPE_LATENCY = COORD_BITS + 3;
	localparam int          RAND_PHASES  = 12;
	localparam int          PHASE_POINTS = 150;
	localparam int          HOLD_CYCLES  = 120;
	localparam int          NUM_DIRECTED = 21;

	// one register setting of the transform
	typedef struct packed {
		logic [15:0] nw;
		logic [15:0] nh;
		logic [15:0] lw;
		logic [15:0] lh;
		logic        mh;
		logic        mv;
		logic        sw;
		tct_rot_t    rot;
	} xform_cfg_t;

	typedef struct packed {
		logic [15:0] sx;
		logic [15:0] sy;
	} screen_pt_t;

	// directed row: setting to use, raw point, and a typed result where it is obvious
	typedef struct packed {
		logic [2:0]  sel;
		logic [15:0] rx;
		logic [15:0] ry;
		logic        known;
		logic [15:0] ex;
		logic [15:0] ey;
	} stim_row_t;

	localparam xform_cfg_t RESET_CFG = '{16'd0, 16'd0, 16'd1, 16'd1, 1'b0, 1'b0, 1'b0, ROT_0};

	localparam xform_cfg_t DIR_CFG [8] = '{
		RESET_CFG,
		// zero native extents with both mirrors: every coordinate goes negative
		'{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, ROT_0},
		// zero native extents unmirrored: divisor of one, clamp to the top
		'{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, ROT_0},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, ROT_0},
		'{16'd800, 16'd480, 16'd320, 16'd240, 1'b1, 1'b0, 1'b1, ROT_90},
		'{16'd4096, 16'd4096, 16'd480, 16'd320, 1'b0, 1'b1, 1'b0, ROT_180},
		// logical extents of zero act as one
		'{16'd1000, 16'd2000, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, ROT_270},
		'{16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 1'b1, 1'b1, 1'b1, ROT_270}
	};

	localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
		'{3'd0, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0},
		'{3'd0, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd0},
		'{3'd1, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0},
		'{3'd1, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 16'd0},
		'{3'd2, 16'd0, 16'd0, 1'b1, 16'd0, 16'd0},
		'{3'd2, 16'd1, 16'd1, 1'b1, 16'hFFFE, 16'hFFFE},
		'{3'd2, 16'hFFFF, 16'd0, 1'b1, 16'hFFFE, 16'd0},
		'{3'd3, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFE, 16'hFFFE},
		'{3'd3, 16'hFFFE, 16'd1, 1'b1, 16'hFFFE, 16'd1},
		'{3'd4, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
		'{3'd4, 16'd799, 16'd479, 1'b0, 16'd0, 16'd0},
		'{3'd4, 16'd800, 16'd480, 1'b0, 16'd0, 16'd0},
		'{3'd4, 16'hFFFF, 16'hFFFF, 1'b0, 16'd0, 16'd0},
		'{3'd5, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
		'{3'd5, 16'd4095, 16'd4095, 1'b0, 16'd0, 16'd0},
		'{3'd5, 16'd2048, 16'd100, 1'b0, 16'd0, 16'd0},
		'{3'd6, 16'd500, 16'd500, 1'b1, 16'd0, 16'd0},
		'{3'd6, 16'hFFFF, 16'd0, 1'b1, 16'd0, 16'd0},
		'{3'd7, 16'd0, 16'd0, 1'b0, 16'd0, 16'd0},
		'{3'd7, 16'd1, 16'hFFFF, 1'b0, 16'd0, 16'd0},
		'{3'd7, 16'hFFFF, 16'd1, 1'b0, 16'd0, 16'd0}
	};

	logic                      clk;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [APB_ADDR_BITS-1:0]  paddr;
	logic [APB_DATA_BITS-1:0]  pwdata;
	logic [APB_DATA_BITS-1:0]  prdata;
	logic                      pready;

	tct_in_if  #(.W(COORD_BITS)) touch_if ();
	tct_out_if #(.W(COORD_BITS)) screen_if ();

	touch_coordinate_transform #(.COORD_BITS(COORD_BITS)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.touch   (touch_if),
		.screen  (screen_if)
	);

	xform_cfg_t active_cfg = RESET_CFG;
	screen_pt_t screen_due [$];
	int         errors      = 0;
	int         n_points    = 0;
	int         n_results   = 0;
	int         n_settings  = 0;
	bit         tx_gaps_on  = 1'b1;
	bit         rx_gaps_on  = 1'b1;
	bit         long_hold_req = 1'b0;

	// clock
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// scale one axis by span / extent and clamp to the span
	function automatic logic [15:0] scale_clamp(longint pos, longint extent, longint span);
		longint q;
		if (pos <= 0)
			return '0;
		q = (pos * span) / ((extent == 0) ? 1 : extent);
		if (q > span - 1)
			q = span - 1;
		return q[15:0];
	endfunction

	// mirror, swap, scale, clamp and rotate one raw point
	function automatic screen_pt_t to_screen_point(xform_cfg_t c, logic [15:0] rx,
			logic [15:0] ry);
		longint     px, py, ext_x, ext_y, span_x, span_y, t;
		logic [15:0] lx, ly;
		screen_pt_t pt;
		px     = rx;
		py     = ry;
		ext_x  = c.nw;
		ext_y  = c.nh;
		span_x = (c.lw == 0) ? 1 : c.lw;
		span_y = (c.lh == 0) ? 1 : c.lh;
		if (c.mh)
			px = ext_x - 1 - px;
		if (c.mv)
			py = ext_y - 1 - py;
		if (c.sw) begin
			t     = px;
			px    = py;
			py    = t;
			t     = ext_x;
			ext_x = ext_y;
			ext_y = t;
		end
		lx = scale_clamp(px, ext_x, span_x);
		ly = scale_clamp(py, ext_y, span_y);
		case (c.rot)
			ROT_90: begin
				pt.sx = ly;
				pt.sy = 16'(span_x - 1 - lx);
			end
			ROT_180: begin
				pt.sx = 16'(span_x - 1 - lx);
				pt.sy = 16'(span_y - 1 - ly);
			end
			ROT_270: begin
				pt.sx = 16'(span_y - 1 - ly);
				pt.sy = lx;
			end
			default: begin
				pt.sx = lx;
				pt.sy = ly;
			end
		endcase
		return pt;
	endfunction

	// extent biased toward the corners of its range
	function automatic logic [15:0] pick_extent();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'd1;
			2: return 16'hFFFF;
			3, 4: return 16'($urandom_range(2, 64));
			5, 6: return 16'($urandom_range(65, 4096));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic xform_cfg_t random_setting(int ph);
		xform_cfg_t c;
		c.nw = pick_extent();
		c.nh = pick_extent();
		c.lw = pick_extent();
		c.lh = pick_extent();
		// logical zero stays rare
		if (c.lw == 0 && $urandom_range(0, 2) != 0)
			c.lw = 16'd1;
		if (c.lh == 0 && $urandom_range(0, 2) != 0)
			c.lh = 16'd1;
		c.mh  = 1'($urandom);
		c.mv  = 1'($urandom);
		c.sw  = 1'($urandom);
		c.rot = tct_rot_t'(ph[1:0]);
		return c;
	endfunction

	// coordinate inside, at the edge of, or past the native extent
	function automatic logic [15:0] pick_coord(logic [15:0] extent);
		case ($urandom_range(0, 5))
			0, 1: return 16'($urandom);
			2: begin
				case ($urandom_range(0, 3))
					0: return 16'd0;
					1: return extent - 16'd1;
					2: return extent;
					default: return 16'hFFFF;
				endcase
			end
			default: return (extent == 0) ? 16'd0 : 16'($urandom_range(0, extent - 1));
		endcase
	endfunction

	// one apb write: setup cycle, then access cycle until pready
	task automatic write_reg(tct_reg_t idx, logic [APB_DATA_BITS-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	// one apb read: setup cycle, then access cycle, data taken at the completing edge
	task automatic read_reg(tct_reg_t idx, output logic [APB_DATA_BITS-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		data = prdata;
	endtask

	// program every register, only while the pipeline is empty
	task automatic apply_cfg(xform_cfg_t c);
		logic [APB_DATA_BITS-1:0] rd;
		write_reg(REG_NATIVE_WIDTH, {16'd0, c.nw});
		write_reg(REG_NATIVE_HEIGHT, {16'd0, c.nh});
		write_reg(REG_LOGICAL_WIDTH, {16'd0, c.lw});
		write_reg(REG_LOGICAL_HEIGHT, {16'd0, c.lh});
		write_reg(REG_MIRROR_H, {31'd0, c.mh});
		write_reg(REG_MIRROR_V, {31'd0, c.mv});
		write_reg(REG_SWAP_AXES, {31'd0, c.sw});
		write_reg(REG_ROTATION, {30'd0, c.rot});
		// read back a wide and a narrow register
		read_reg(REG_LOGICAL_WIDTH, rd);
		if (rd !== {16'd0, c.lw}) begin
			$error("logical_width: expected %0d, got %0d", c.lw, rd);
			errors++;
		end
		read_reg(REG_ROTATION, rd);
		if (rd !== {30'd0, c.rot}) begin
			$error("rotation_quadrant: expected %0d, got %0d", c.rot, rd);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		active_cfg = c;
		n_settings++;
	endtask

	// offer one touch point, with an optional idle burst ahead of it
	task automatic send_point(logic [15:0] x, logic [15:0] y, logic known,
			logic [15:0] ex, logic [15:0] ey);
		screen_pt_t want;
		int         gap;
		@(negedge clk);
		if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			touch_if.valid <= 1'b0;
			repeat (gap)
				@(negedge clk);
		end
		touch_if.valid <= 1'b1;
		touch_if.raw_x <= x;
		touch_if.raw_y <= y;
		@(posedge clk);
		while (!touch_if.ready)
			@(posedge clk);
		want = known ? screen_pt_t'{ex, ey} : to_screen_point(active_cfg, x, y);
		screen_due.push_back(want);
		n_points++;
	endtask

	// stop offering and let every pending point come out
	task automatic finish_burst();
		@(negedge clk);
		touch_if.valid <= 1'b0;
		while (screen_due.size() != 0)
			@(posedge clk);
	endtask

	// screen side ready: short random stalls, plus one long hold on request
	initial begin
		int stall_left;
		bit hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		screen_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left == 0) begin
				if (long_hold_req && !hold_done) begin
					stall_left = HOLD_CYCLES;
					hold_done  = 1'b1;
				end else if (rx_gaps_on && $urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(1, 6);
				end
			end
			if (stall_left > 0) begin
				screen_if.ready <= 1'b0;
				stall_left--;
			end else begin
				screen_if.ready <= 1'b1;
			end
		end
	end

	// compare each screen transfer with the oldest pending point
	always @(posedge clk) begin
		screen_pt_t want;
		if (arst_n && screen_if.valid && screen_if.ready) begin
			n_results++;
			if (screen_due.size() == 0) begin
				$error("unexpected screen point x=%0d y=%0d", screen_if.screen_x,
					screen_if.screen_y);
				errors++;
			end else begin
				want = screen_due.pop_front();
				if (screen_if.screen_x !== want.sx) begin
					$error("screen_x: expected %0d, got %0d", want.sx, screen_if.screen_x);
					errors++;
				end
				if (screen_if.screen_y !== want.sy) begin
					$error("screen_y: expected %0d, got %0d", want.sy, screen_if.screen_y);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		logic [2:0] cur_sel;
		xform_cfg_t c;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		touch_if.valid = 1'b0;
		touch_if.raw_x = '0;
		touch_if.raw_y = '0;
		repeat (12)
			@(negedge clk);
		arst_n = 1'b1;

		// directed rows, first under the reset values of the registers
		cur_sel = 3'd0;
		for (int i = 0; i < NUM_DIRECTED; i++) begin
			if (DIRECTED[i].sel != cur_sel) begin
				finish_burst();
				cur_sel = DIRECTED[i].sel;
				apply_cfg(DIR_CFG[cur_sel]);
			end
			send_point(DIRECTED[i].rx, DIRECTED[i].ry, DIRECTED[i].known,
				DIRECTED[i].ex, DIRECTED[i].ey);
		end
		finish_burst();

		// random settings, random points; last phases run without idling
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			c = random_setting(ph);
			apply_cfg(c);
			if (ph >= RAND_PHASES - 2) begin
				tx_gaps_on = 1'b0;
				rx_gaps_on = 1'b0;
			end
			for (int n = 0; n < PHASE_POINTS; n++) begin
				// long output stall while points keep coming
				if (ph == 3 && n == 20)
					long_hold_req = 1'b1;
				send_point(pick_coord(c.nw), pick_coord(c.nh), 1'b0, 16'd0, 16'd0);
			end
			finish_burst();
		end

		repeat (PIPE_LATENCY + 8)
			@(posedge clk);
		$display("covered %0d touch points under %0d register settings, %0d screen points",
			n_points, n_settings + 1, n_results);
		$display("all rotations, mirror and swap mixes, zero extents and one long stall");
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
